[rtl/dap_pkg.sv]
// ----------------------------------------------------------------------------
// dap_pkg
// Shared types and constants for the distance attenuation and stereo pan block.
// ----------------------------------------------------------------------------
package dap_pkg;

    localparam int CoordW  = 16;
    localparam int DiffW   = CoordW + 1;        // exact coordinate difference
    localparam int RadW    = 2 * DiffW;         // sum of two squares
    localparam int RootW   = DiffW;             // integer root of the sum
    localparam int RemW    = RootW + 3;         // root remainder with two new bits
    localparam int PanW    = 16;
    localparam int DistW   = 17;
    localparam int GainW   = 8;
    localparam int QuoW    = 8;                 // quotient bits, one per divide cell
    localparam int NumW    = GainW + DistW;     // dividend of both divisions
    localparam int DenW    = DistW;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 17;

    localparam int SqrtCells = RootW;
    localparam int DivCells  = QuoW;

    localparam logic [GainW-1:0]   FullGain   = 8'd255;
    localparam logic [PanW-1:0]    PanReset   = 16'd256;
    localparam logic [DistW-1:0]   DistReset  = 17'd1024;

    localparam logic [CfgIdxW-1:0] CfgPanFalloff  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgDistFalloff = 2'd1;

    typedef struct packed {
        logic [GainW-1:0]         base_volume;
        logic signed [CoordW-1:0] source_x;
        logic signed [CoordW-1:0] source_y;
        logic signed [CoordW-1:0] listener_x;
        logic signed [CoordW-1:0] listener_y;
    } t_in_item;

    typedef struct packed {
        logic [GainW-1:0] attenuated_volume;
        logic [GainW-1:0] left_gain;
        logic [GainW-1:0] right_gain;
    } t_out_item;

    typedef struct packed {
        logic [RadW-1:0]  rad;
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
    } t_sqrt_data;

    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [DenW-1:0] den;
        logic [QuoW-1:0] quo;
    } t_div_data;

endpackage

[rtl/dap_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// dap_sqrt_cell
// One restoring square-root step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module dap_sqrt_cell
    import dap_pkg::*;
(
    input  logic       i_clk,
    input  t_sqrt_data i_data,
    output t_sqrt_data o_data
);

    t_sqrt_data        n_data;
    t_sqrt_data        r_data;
    logic [RemW-1:0]   rem_sh;
    logic [RemW-1:0]   trial;

    always_comb begin
        rem_sh     = {i_data.rem[RemW-3:0], i_data.rad[RadW-1 -: 2]};
        trial      = {1'b0, i_data.root, 2'b01};
        n_data.rad = {i_data.rad[RadW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_data.rem  = rem_sh - trial;
            n_data.root = {i_data.root[RootW-2:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh;
            n_data.root = {i_data.root[RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/dap_div_cell.sv]
// ----------------------------------------------------------------------------
// dap_div_cell
// One restoring division step: yields the quotient bit of weight 2**SHIFT.
// ----------------------------------------------------------------------------
module dap_div_cell
    import dap_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic      i_clk,
    input  t_div_data i_data,
    output t_div_data o_data
);

    t_div_data       n_data;
    t_div_data       r_data;
    logic [NumW-1:0] dsh;

    always_comb begin
        dsh        = NumW'(i_data.den) << SHIFT;
        n_data.den = i_data.den;
        if (i_data.rem >= dsh) begin
            n_data.rem = i_data.rem - dsh;
            n_data.quo = {i_data.quo[QuoW-2:0], 1'b1};
        end else begin
            n_data.rem = i_data.rem;
            n_data.quo = {i_data.quo[QuoW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/distance_attenuation_stereo_pan_top.sv]
// ----------------------------------------------------------------------------
// distance_attenuation_stereo_pan_top
// Distance attenuation and left/right pan gains for one sound source per item.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and pulse i_start; the item transfers on every edge where
//   i_start is high (o_busy stays low, one item can enter each cycle).
//   Each item yields o_done high for one cycle with o_res; the
//   receiver must take it then, it cannot stall the block.
//   Throughput is one item per cycle. The pipeline is a row of cells:
//   3 stages (difference, squares, sum), 17 square-root cells (one root bit
//   each), 1 multiply stage, 8 divide cells (one quotient bit each, the
//   volume and the pan division side by side) and the output register.
//   Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
//   (0 = pan falloff, 1 = distance falloff); other indexes are dropped.
//   Write only while no item is in flight.
//   Reset (synchronous, active low) empties the pipeline and restores the
//   falloffs to 256 and 1024.
// ----------------------------------------------------------------------------
module distance_attenuation_stereo_pan_top
    import dap_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_in_item           i_item,
    output logic               o_busy,
    output logic               o_done,
    output t_out_item          o_res,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_wdata
);

    // configuration registers
    logic [PanW-1:0]  r_pan_fall;
    logic [DistW-1:0] r_dist_fall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_fall  <= PanReset;
            r_dist_fall <= DistReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgPanFalloff:  r_pan_fall  <= i_cfg_wdata[PanW-1:0];
                CfgDistFalloff: r_dist_fall <= i_cfg_wdata[DistW-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // stage 1: exact differences and their magnitudes
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic                    r1_vld;
    logic [GainW-1:0]        r1_vol;
    logic [DiffW-1:0]        r1_adx;
    logic [DiffW-1:0]        r1_ady;
    logic                    r1_pos;
    logic                    r1_neg;

    always_comb begin
        dx = DiffW'(i_item.source_x) - DiffW'(i_item.listener_x);
        dy = DiffW'(i_item.source_y) - DiffW'(i_item.listener_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
        end
        r1_vol <= i_item.base_volume;
        r1_adx <= dx[DiffW-1] ? -dx : dx;
        r1_ady <= dy[DiffW-1] ? -dy : dy;
        r1_pos <= !dx[DiffW-1] && (dx != '0);
        r1_neg <= dx[DiffW-1];
    end

    // stage 2: squares, and the pan dividend (zero at or beyond the falloff)
    logic              r2_vld;
    logic [GainW-1:0]  r2_vol;
    logic              r2_pos;
    logic              r2_neg;
    logic [RadW-1:0]   r2_sqx;
    logic [RadW-1:0]   r2_sqy;
    logic [NumW-1:0]   r2_pnum;
    logic [DenW-1:0]   r2_pden;
    logic [DiffW-1:0]  pan_ext;

    assign pan_ext = DiffW'(r_pan_fall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_vol  <= r1_vol;
        r2_pos  <= r1_pos;
        r2_neg  <= r1_neg;
        r2_sqx  <= RadW'(r1_adx) * RadW'(r1_adx);
        r2_sqy  <= RadW'(r1_ady) * RadW'(r1_ady);
        r2_pnum <= (r1_adx >= pan_ext) ? '0
                   : NumW'(FullGain) * NumW'(pan_ext - r1_adx);
        r2_pden <= (pan_ext == '0) ? DenW'(1) : DenW'(pan_ext);
    end

    // stage 3: radicand
    logic             r3_vld;
    logic [GainW-1:0] r3_vol;
    logic             r3_pos;
    logic             r3_neg;
    logic [RadW-1:0]  r3_sum;
    logic [NumW-1:0]  r3_pnum;
    logic [DenW-1:0]  r3_pden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_vol  <= r2_vol;
        r3_pos  <= r2_pos;
        r3_neg  <= r2_neg;
        r3_sum  <= r2_sqx + r2_sqy;
        r3_pnum <= r2_pnum;
        r3_pden <= r2_pden;
    end

    // square-root row, with the item's side data advancing next to it
    t_sqrt_data       sq_data [SqrtCells+1];
    logic             r_sq_vld  [SqrtCells+1];
    logic [GainW-1:0] r_sq_vol  [SqrtCells+1];
    logic             r_sq_pos  [SqrtCells+1];
    logic             r_sq_neg  [SqrtCells+1];
    logic [NumW-1:0]  r_sq_pnum [SqrtCells+1];
    logic [DenW-1:0]  r_sq_pden [SqrtCells+1];

    always_comb begin
        sq_data[0].rad = r3_sum;
        sq_data[0].rem = '0;
        sq_data[0].root = '0;
        r_sq_vld[0]  = r3_vld;
        r_sq_vol[0]  = r3_vol;
        r_sq_pos[0]  = r3_pos;
        r_sq_neg[0]  = r3_neg;
        r_sq_pnum[0] = r3_pnum;
        r_sq_pden[0] = r3_pden;
    end

    for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
        dap_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_data (sq_data[k]),
            .o_data (sq_data[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            r_sq_vol[k+1]  <= r_sq_vol[k];
            r_sq_pos[k+1]  <= r_sq_pos[k];
            r_sq_neg[k+1]  <= r_sq_neg[k];
            r_sq_pnum[k+1] <= r_sq_pnum[k];
            r_sq_pden[k+1] <= r_sq_pden[k];
        end
    end

    // multiply stage: volume dividend, zero at or beyond the distance falloff
    logic [RootW-1:0] src_dist;
    logic             r4_vld;
    logic [GainW-1:0] r4_vol;
    logic             r4_pos;
    logic             r4_neg;
    t_div_data        r4_att;
    t_div_data        r4_pan;

    assign src_dist = sq_data[SqrtCells].root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r_sq_vld[SqrtCells];
        end
        r4_vol     <= r_sq_vol[SqrtCells];
        r4_pos     <= r_sq_pos[SqrtCells];
        r4_neg     <= r_sq_neg[SqrtCells];
        r4_att.rem <= (src_dist >= r_dist_fall) ? '0
                      : NumW'(r_sq_vol[SqrtCells]) * NumW'(r_dist_fall - src_dist);
        r4_att.den <= (r_dist_fall == '0) ? DenW'(1) : r_dist_fall;
        r4_att.quo <= '0;
        r4_pan.rem <= r_sq_pnum[SqrtCells];
        r4_pan.den <= r_sq_pden[SqrtCells];
        r4_pan.quo <= '0;
    end

    // divide row: volume and pan quotients, most significant bit first
    t_div_data        dv_att [DivCells+1];
    t_div_data        dv_pan [DivCells+1];
    logic             r_dv_vld [DivCells+1];
    logic [GainW-1:0] r_dv_vol [DivCells+1];
    logic             r_dv_pos [DivCells+1];
    logic             r_dv_neg [DivCells+1];

    always_comb begin
        dv_att[0]   = r4_att;
        dv_pan[0]   = r4_pan;
        r_dv_vld[0] = r4_vld;
        r_dv_vol[0] = r4_vol;
        r_dv_pos[0] = r4_pos;
        r_dv_neg[0] = r4_neg;
    end

    for (genvar k = 0; k < DivCells; k++) begin : g_div
        dap_div_cell #(.SHIFT(DivCells - 1 - k)) u_att (
            .i_clk  (i_clk),
            .i_data (dv_att[k]),
            .o_data (dv_att[k+1])
        );

        dap_div_cell #(.SHIFT(DivCells - 1 - k)) u_pan (
            .i_clk  (i_clk),
            .i_data (dv_pan[k]),
            .o_data (dv_pan[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
            r_dv_vol[k+1] <= r_dv_vol[k];
            r_dv_pos[k+1] <= r_dv_pos[k];
            r_dv_neg[k+1] <= r_dv_neg[k];
        end
    end

    // output register: near side full gain, far side the pan quotient
    logic             r_done;
    t_out_item        r_res;
    logic [GainW-1:0] r_out_vol;
    logic [GainW-1:0] far_gain;

    assign far_gain = dv_pan[DivCells].quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv_vld[DivCells];
        end
        r_out_vol               <= r_dv_vol[DivCells];
        r_res.attenuated_volume <= dv_att[DivCells].quo;
        r_res.left_gain         <= r_dv_pos[DivCells] ? far_gain : FullGain;
        r_res.right_gain        <= r_dv_neg[DivCells] ? far_gain : FullGain;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // at most one side is attenuated
    a_one_far_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.left_gain == FullGain || o_res.right_gain == FullGain))
        else $error("both pan gains below full");

    // the attenuated volume never exceeds the base volume
    a_vol_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.attenuated_volume <= r_out_vol))
        else $error("attenuated volume above base volume");

    // an item at the end of the divide row was valid in the multiply stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[DivCells] |-> $past(r4_vld, DivCells))
        else $error("divide row lost track of an item");

endmodule
